[rtl/core/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Console line editor package
// Shared codes, field widths and the job record passed from the editor to
// the result emitter.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int KeyWidth   = 8;
   localparam int CountWidth = 7;

   localparam logic [KeyWidth-1:0] KEY_BS  = 8'h08;
   localparam logic [KeyWidth-1:0] KEY_DEL = 8'h7F;
   localparam logic [KeyWidth-1:0] KEY_CR  = 8'h0D;
   localparam logic [KeyWidth-1:0] KEY_LF  = 8'h0A;
   localparam logic [KeyWidth-1:0] KEY_SP  = 8'h20;

   localparam logic ACTION_KEY  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic RESULT_ECHO = 1'b0;
   localparam logic RESULT_READ = 1'b1;

   localparam logic [CountWidth-1:0] LIMIT_RESET = 7'd127;

   typedef enum logic [1:0] {
      JOB_ECHO  = 2'd0,
      JOB_READ  = 2'd1,
      JOB_EOL   = 2'd2,
      JOB_ERASE = 2'd3
   } job_kind_type;

   typedef struct packed {
      logic                  valid;
      job_kind_type          kind;
      logic [KeyWidth-1:0]   key;
      logic                  hit;
      logic [CountWidth-1:0] length;
   } job_type;

endpackage

[rtl/core/cle_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. The read data
// register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/cle_edit.sv]
// ----------------------------------------------------------------------------
// Console line editor: line state
// Accepts input words, updates the character count and the closed flag,
// writes stored characters into the line RAM and issues reads, and hands at most
// one job per word to the result emitter.
// ----------------------------------------------------------------------------
module cle_edit #(
   parameter int LINE_DEPTH = 128,
   parameter int AW         = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_action,
   input  logic [cle_pkg::KeyWidth-1:0]       req_key,
   input  logic [cle_pkg::CountWidth-1:0]     req_index,
   input  logic                               csr_wen,
   input  logic [cle_pkg::CountWidth-1:0]     csr_wdata,
   input  logic                               slot_free,
   output cle_pkg::job_type                   job,
   output logic                               ram_wr_en,
   output logic [AW-1:0]                      ram_wr_addr,
   output logic [cle_pkg::KeyWidth-1:0]       ram_wr_data,
   output logic                               ram_rd_en,
   output logic [AW-1:0]                      ram_rd_addr
);

   logic [cle_pkg::CountWidth-1:0]    count_ff;
   logic [cle_pkg::CountWidth-1:0]    count_in;
   logic                              closed_ff;
   logic                              closed_in;
   logic [cle_pkg::CountWidth-1:0]    limit_ff;
   logic [cle_pkg::CountWidth-1:0]    limit_in;
   logic                              accept;
   logic [cle_pkg::CountWidth-1:0]    base;
   logic                              store_ok;
   logic [AW+cle_pkg::CountWidth-1:0] rd_ext;
   logic [AW+cle_pkg::CountWidth-1:0] wr_ext;

   assign req_tready = slot_free;
   assign accept     = req_tvalid && slot_free;
   assign base       = closed_ff ? '0 : count_ff;
   assign store_ok   = (base < limit_ff) && (32'(base) < LINE_DEPTH);

   assign rd_ext      = {{AW{1'b0}}, req_index};
   assign wr_ext      = {{AW{1'b0}}, base};
   assign ram_rd_addr = rd_ext[AW-1:0];
   assign ram_wr_addr = wr_ext[AW-1:0];
   assign ram_wr_data = req_key;

   always_comb begin
      count_in    = count_ff;
      closed_in   = closed_ff;
      limit_in    = csr_wen ? csr_wdata : limit_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      job.valid   = 1'b0;
      job.kind    = cle_pkg::JOB_ECHO;
      job.key     = req_key;
      job.hit     = req_index < count_ff;
      job.length  = count_ff;
      if (accept) begin
         if (req_action == cle_pkg::ACTION_READ) begin
            ram_rd_en = 1'b1;
            job.valid = 1'b1;
            job.kind  = cle_pkg::JOB_READ;
         end else begin
            closed_in = 1'b0;
            count_in  = base;
            job.valid = 1'b1;
            if (req_key == cle_pkg::KEY_CR) begin
               closed_in = 1'b1;
               job.kind  = cle_pkg::JOB_EOL;
            end else if (req_key == cle_pkg::KEY_BS || req_key == cle_pkg::KEY_DEL) begin
               job.kind = cle_pkg::JOB_ERASE;
               if (base == '0) begin
                  job.valid = 1'b0;
               end else begin
                  count_in = base - 1'b1;
               end
            end else if (store_ok) begin
               ram_wr_en = 1'b1;
               count_in  = base + 1'b1;
            end
            job.length = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
         limit_ff  <= cle_pkg::LIMIT_RESET;
      end else begin
         count_ff  <= count_in;
         closed_ff <= closed_in;
         limit_ff  <= limit_in;
      end
   end

endmodule

[rtl/core/cle_emit.sv]
// ----------------------------------------------------------------------------
// Console line editor: result emitter
// Holds the current job and steps through its one to three result words,
// one per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module cle_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  cle_pkg::job_type               job,
   input  logic [cle_pkg::KeyWidth-1:0]   ram_rd_data,
   output logic                           slot_free,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_kind,
   output logic [cle_pkg::KeyWidth-1:0]   rsp_byte,
   output logic                           rsp_last,
   output logic                           rsp_done,
   output logic [cle_pkg::CountWidth-1:0] rsp_length
);

   cle_pkg::job_type               job_ff;
   cle_pkg::job_type               job_in;
   logic [1:0]                     step_ff;
   logic [1:0]                     step_in;
   logic                           valid_ff;
   logic                           valid_in;
   logic                           kind_ff;
   logic [cle_pkg::KeyWidth-1:0]   byte_ff;
   logic                           last_ff;
   logic                           done_ff;
   logic [cle_pkg::CountWidth-1:0] length_ff;
   logic                           load;
   logic                           cur_kind;
   logic [cle_pkg::KeyWidth-1:0]   cur_byte;
   logic                           cur_last;
   logic                           cur_done;

   always_comb begin
      cur_kind = cle_pkg::RESULT_ECHO;
      cur_byte = job_ff.key;
      cur_last = 1'b1;
      cur_done = 1'b0;
      case (job_ff.kind)
         cle_pkg::JOB_ECHO: begin
            cur_byte = job_ff.key;
         end
         cle_pkg::JOB_READ: begin
            cur_kind = cle_pkg::RESULT_READ;
            cur_byte = job_ff.hit ? ram_rd_data : '0;
         end
         cle_pkg::JOB_EOL: begin
            cur_byte = (step_ff == 2'd0) ? cle_pkg::KEY_LF : cle_pkg::KEY_CR;
            cur_last = step_ff == 2'd1;
            cur_done = 1'b1;
         end
         cle_pkg::JOB_ERASE: begin
            cur_byte = (step_ff == 2'd1) ? cle_pkg::KEY_SP : cle_pkg::KEY_BS;
            cur_last = step_ff == 2'd2;
         end
         default: begin
            cur_byte = job_ff.key;
         end
      endcase
   end

   assign load      = job_ff.valid && (!valid_ff || rsp_tready);
   assign slot_free = !job_ff.valid || (load && cur_last);

   always_comb begin
      job_in  = job_ff;
      step_in = step_ff;
      if (slot_free) begin
         job_in  = job;
         step_in = '0;
      end else if (load) begin
         step_in = step_ff + 1'b1;
      end
      valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         job_ff.valid <= job_in.valid;
         valid_ff     <= valid_in;
      end
      job_ff.kind   <= job_in.kind;
      job_ff.key    <= job_in.key;
      job_ff.hit    <= job_in.hit;
      job_ff.length <= job_in.length;
      step_ff       <= step_in;
      if (load) begin
         kind_ff   <= cur_kind;
         byte_ff   <= cur_byte;
         last_ff   <= cur_last;
         done_ff   <= cur_done;
         length_ff <= job_ff.length;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_last   = last_ff;
   assign rsp_done   = done_ff;
   assign rsp_length = length_ff;

endmodule

[rtl/core/console_line_editor.sv]
// ----------------------------------------------------------------------------
// Console line editor
// Edits a stored console line from received key bytes and returns echo words
// and stored line bytes.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word for a plain key or a read, two
// for a carriage return, three for a backspace or delete, and none for an
// erase on an empty line. The emitter drives one result word per cycle into
// the output register while rsp_tready does not stall it, and a new word is
// accepted in the same cycle as the previous word's last result moves to
// that register. The line is held in a RAM with registered read, read in the
// cycle after a read word is accepted. There is no clearing pass after
// reset; bytes beyond the current length read as zero.
module console_line_editor #(
   parameter int LINE_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_byte[7:0], read_index[14:8], zero[15]
   input  logic        req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], line_done[8], line_length[15:9]
   output logic        rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [6:0]  csr_wdata
);

   localparam int AW = $clog2(LINE_DEPTH);

   cle_pkg::job_type               job;
   logic                           slot_free;
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [cle_pkg::KeyWidth-1:0]   ram_wr_data;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [cle_pkg::KeyWidth-1:0]   ram_rd_data;
   logic [cle_pkg::KeyWidth-1:0]   rsp_byte;
   logic                           rsp_done;
   logic [cle_pkg::CountWidth-1:0] rsp_length;

   cle_ram #(
      .WIDTH (cle_pkg::KeyWidth),
      .DEPTH (LINE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cle_edit #(
      .LINE_DEPTH (LINE_DEPTH),
      .AW         (AW)
   ) u_edit (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_action  (req_tuser),
      .req_key     (req_tdata[7:0]),
      .req_index   (req_tdata[14:8]),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .slot_free   (slot_free),
      .job         (job),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   cle_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .ram_rd_data (ram_rd_data),
      .slot_free   (slot_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_byte    (rsp_byte),
      .rsp_last    (rsp_tlast),
      .rsp_done    (rsp_done),
      .rsp_length  (rsp_length)
   );

   assign rsp_tdata = {rsp_length, rsp_done, rsp_byte};

endmodule
